// ===== hdl/rsakg_pkg.sv =====
// Shared types and constants of the small RSA key generator.
`timescale 1ns / 1ps

package rsakg_pkg;

    localparam int WordW  = 32;
    localparam int HalfW  = 16;
    localparam int AccW   = 34;
    localparam int StatW  = 2;
    localparam int TrialW = 9;
    localparam int CandW  = 17;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_NEXT_Q,
        OP_DIV_PT,
        OP_INC_I,
        OP_MUL,
        OP_SEL_E,
        OP_ES_INIT,
        OP_G_INIT,
        OP_DIV_G,
        OP_G_STEP,
        OP_INC_C,
        OP_E_FOUND,
        OP_INV_INIT,
        OP_R1_SET,
        OP_DIV_EG,
        OP_EG_STEP,
        OP_FIN1,
        OP_FIN2,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [StatW-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_PRIME = 2'd1,
        ST_NO_INV    = 2'd2
    } t_status;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic x_lt2;
        logic ii_gt_x;
        logic div_done;
        logic rem_zero;
        logic c_ok;
        logic b_zero;
        logic a_one;
        logic cfg_zero;
        logic phi_lt2;
        logic r1_zero;
        logic r0_one;
        logic out_busy;
    } t_dp_flags;

endpackage

// ===== hdl/rsakg_in_if.sv =====
// Input channel carrying the two candidate primes.
`timescale 1ns / 1ps

interface rsakg_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_prime;
    logic [15:0] second_prime;

    modport source (output valid, output first_prime, output second_prime, input ready);
    modport sink   (input valid, input first_prime, input second_prime, output ready);
endinterface

// ===== hdl/rsakg_out_if.sv =====
// Output channel carrying one generated key set.
`timescale 1ns / 1ps

interface rsakg_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] modulus;
    logic [31:0] totient;
    logic [15:0] exponent_used;
    logic [31:0] private_exponent;

    modport source (output valid, output status, output modulus, output totient,
                    output exponent_used, output private_exponent, input ready);
    modport sink   (input valid, input status, input modulus, input totient,
                    input exponent_used, input private_exponent, output ready);
endinterface

// ===== hdl/rsakg_div.sv =====
// Bit-serial restoring divider with a multiply-accumulate of the quotient.
`timescale 1ns / 1ps

module rsakg_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rsakg_pkg::WordW-1:0]      i_dividend,
    input  logic [rsakg_pkg::WordW-1:0]      i_divisor,
    input  logic signed [rsakg_pkg::AccW-1:0] i_mul,
    output logic                             o_done,
    output logic [rsakg_pkg::WordW-1:0]      o_rem,
    output logic signed [rsakg_pkg::AccW-1:0] o_acc
);

    logic                              r_busy;
    logic                              r_done;
    logic [4:0]                        r_cnt;
    logic [rsakg_pkg::WordW-1:0]       r_rem;
    logic [rsakg_pkg::WordW-1:0]       r_quo;
    logic [rsakg_pkg::WordW-1:0]       r_div;
    logic signed [rsakg_pkg::AccW-1:0] r_mul;
    logic signed [rsakg_pkg::AccW-1:0] r_acc;

    logic [rsakg_pkg::WordW:0]         w_trial;
    logic                              w_ge;
    logic [rsakg_pkg::WordW:0]         w_rem_nx;
    logic signed [rsakg_pkg::AccW-1:0] w_acc_nx;

    always_comb begin
        w_trial  = {r_rem, r_quo[rsakg_pkg::WordW-1]};
        w_ge     = (w_trial >= {1'b0, r_div});
        w_rem_nx = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
        // quotient bits arrive MSB first, so doubling the sum builds q * mul
        w_acc_nx = (r_acc <<< 1) + (w_ge ? r_mul : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_mul <= i_mul;
            r_acc <= '0;
        end else if (r_busy) begin
            r_rem <= w_rem_nx[rsakg_pkg::WordW-1:0];
            r_quo <= {r_quo[rsakg_pkg::WordW-2:0], 1'b0};
            r_acc <= w_acc_nx;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;

endmodule

// ===== hdl/rsakg_dp.sv =====
// Datapath: operand registers, shared divider and the result register.
`timescale 1ns / 1ps

module rsakg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsakg_pkg::t_dp_cmd            i_cmd,
    output rsakg_pkg::t_dp_flags          o_flags,
    input  logic [rsakg_pkg::HalfW-1:0]   i_first_prime,
    input  logic [rsakg_pkg::HalfW-1:0]   i_second_prime,
    input  logic [rsakg_pkg::HalfW-1:0]   i_cfg_exp,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [rsakg_pkg::StatW-1:0]   o_status,
    output logic [rsakg_pkg::WordW-1:0]   o_modulus,
    output logic [rsakg_pkg::WordW-1:0]   o_totient,
    output logic [rsakg_pkg::HalfW-1:0]   o_exponent_used,
    output logic [rsakg_pkg::WordW-1:0]   o_private_exponent
);

    logic [rsakg_pkg::HalfW-1:0]       r_p, r_q, r_x, r_e;
    logic [rsakg_pkg::TrialW-1:0]      r_i;
    logic [rsakg_pkg::CandW-1:0]       r_c;
    logic [rsakg_pkg::WordW-1:0]       r_n, r_phi, r_a, r_b, r_r0, r_r1, r_d;
    logic signed [rsakg_pkg::AccW-1:0] r_t0, r_t1;

    logic                              r_ovalid;
    logic [rsakg_pkg::StatW-1:0]       r_ostat;
    logic [rsakg_pkg::WordW-1:0]       r_on, r_ophi, r_od;
    logic [rsakg_pkg::HalfW-1:0]       r_oe;

    logic                              w_start;
    logic [rsakg_pkg::WordW-1:0]       w_dvd, w_dvs, w_rem;
    logic signed [rsakg_pkg::AccW-1:0] w_mul, w_acc, w_fix;
    logic [2*rsakg_pkg::TrialW-1:0]    w_ii;
    logic                              w_done;

    rsakg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .i_mul      (w_mul),
        .o_done     (w_done),
        .o_rem      (w_rem),
        .o_acc      (w_acc)
    );

    always_comb begin
        w_start = 1'b0;
        w_dvd   = r_a;
        w_dvs   = r_b;
        w_mul   = '0;
        case (i_cmd.op)
            rsakg_pkg::OP_DIV_PT: begin
                w_start = 1'b1;
                w_dvd   = {16'd0, r_x};
                w_dvs   = {23'd0, r_i};
            end
            rsakg_pkg::OP_DIV_G: begin
                w_start = 1'b1;
            end
            rsakg_pkg::OP_INV_INIT: begin
                w_start = 1'b1;
                w_dvd   = {16'd0, r_e};
                w_dvs   = r_phi;
            end
            rsakg_pkg::OP_DIV_EG: begin
                w_start = 1'b1;
                w_dvd   = r_r0;
                w_dvs   = r_r1;
                w_mul   = r_t1;
            end
            default: ;
        endcase
    end

    assign w_ii  = r_i * r_i;
    assign w_fix = r_t0 + $signed({2'b00, r_phi});

    always_comb begin
        o_flags.x_lt2    = (r_x < 16'd2);
        o_flags.ii_gt_x  = (w_ii > {2'b00, r_x});
        o_flags.div_done = w_done;
        o_flags.rem_zero = (w_rem == '0);
        o_flags.c_ok     = !r_c[rsakg_pkg::CandW-1] && ({15'd0, r_c} < r_phi);
        o_flags.b_zero   = (r_b == '0);
        o_flags.a_one    = (r_a == 32'd1);
        o_flags.cfg_zero = (i_cfg_exp == '0);
        o_flags.phi_lt2  = (r_phi < 32'd2);
        o_flags.r1_zero  = (r_r1 == '0);
        o_flags.r0_one   = (r_r0 == 32'd1);
        o_flags.out_busy = r_ovalid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rsakg_pkg::OP_LOAD: begin
                r_p <= i_first_prime;
                r_q <= i_second_prime;
                r_x <= i_first_prime;
                r_i <= 9'd2;
            end
            rsakg_pkg::OP_NEXT_Q: begin
                r_x <= r_q;
                r_i <= 9'd2;
            end
            rsakg_pkg::OP_INC_I:   r_i <= r_i + 9'd1;
            rsakg_pkg::OP_MUL: begin
                r_n   <= r_p * r_q;
                r_phi <= (r_p - 16'd1) * (r_q - 16'd1);
            end
            rsakg_pkg::OP_SEL_E:   r_e <= i_cfg_exp;
            rsakg_pkg::OP_ES_INIT: begin
                r_c <= 17'd2;
                r_e <= '0;
            end
            rsakg_pkg::OP_G_INIT: begin
                r_a <= {15'd0, r_c};
                r_b <= r_phi;
            end
            rsakg_pkg::OP_G_STEP: begin
                r_a <= r_b;
                r_b <= w_rem;
            end
            rsakg_pkg::OP_INC_C:   r_c <= r_c + 17'd1;
            rsakg_pkg::OP_E_FOUND: r_e <= r_c[rsakg_pkg::HalfW-1:0];
            rsakg_pkg::OP_INV_INIT: begin
                r_r0 <= r_phi;
                r_t0 <= '0;
                r_t1 <= 34'sd1;
            end
            rsakg_pkg::OP_R1_SET:  r_r1 <= w_rem;
            rsakg_pkg::OP_EG_STEP: begin
                r_r0 <= r_r1;
                r_r1 <= w_rem;
                r_t0 <= r_t1;
                r_t1 <= r_t0 - w_acc;
            end
            rsakg_pkg::OP_FIN1:
                r_d <= r_t0[rsakg_pkg::AccW-1] ? w_fix[rsakg_pkg::WordW-1:0]
                                               : r_t0[rsakg_pkg::WordW-1:0];
            rsakg_pkg::OP_FIN2:
                if (r_d < 32'd2) begin
                    r_d <= r_d + r_phi;
                end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == rsakg_pkg::OP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rsakg_pkg::OP_EMIT) begin
            r_ostat <= i_cmd.status;
            if (i_cmd.status == rsakg_pkg::ST_NOT_PRIME) begin
                r_on   <= '0;
                r_ophi <= '0;
                r_oe   <= '0;
            end else begin
                r_on   <= r_n;
                r_ophi <= r_phi;
                r_oe   <= r_e;
            end
            r_od <= (i_cmd.status == rsakg_pkg::ST_OK) ? r_d : '0;
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_status           = r_ostat;
    assign o_modulus          = r_on;
    assign o_totient          = r_ophi;
    assign o_exponent_used    = r_oe;
    assign o_private_exponent = r_od;

endmodule

// ===== hdl/rsakg_ctrl.sv =====
// Controller: sequences primality test, exponent search and inverse.
`timescale 1ns / 1ps

module rsakg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rsakg_pkg::t_dp_flags i_flags,
    output rsakg_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_PT_CHK, S_PT_DIV, S_MUL, S_CFG_E, S_ES_CHK, S_G_CHK, S_G_DIV,
        S_INV_CHK, S_INV_MOD, S_EG_CHK, S_EG_DIV, S_FIN1, S_FIN2, S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic               r_on_q, n_on_q;
    rsakg_pkg::t_status r_status, n_status;
    rsakg_pkg::t_dp_op  w_op;

    always_comb begin
        n_state  = r_state;
        n_on_q   = r_on_q;
        n_status = r_status;
        w_op     = rsakg_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE:
                if (i_in_valid) begin
                    w_op    = rsakg_pkg::OP_LOAD;
                    n_on_q  = 1'b0;
                    n_state = S_PT_CHK;
                end
            S_PT_CHK:
                if (i_flags.x_lt2) begin
                    n_status = rsakg_pkg::ST_NOT_PRIME;
                    n_state  = S_EMIT;
                end else if (i_flags.ii_gt_x) begin
                    if (!r_on_q) begin
                        w_op   = rsakg_pkg::OP_NEXT_Q;
                        n_on_q = 1'b1;
                    end else begin
                        n_state = S_MUL;
                    end
                end else begin
                    w_op    = rsakg_pkg::OP_DIV_PT;
                    n_state = S_PT_DIV;
                end
            S_PT_DIV:
                if (i_flags.div_done) begin
                    if (i_flags.rem_zero) begin
                        n_status = rsakg_pkg::ST_NOT_PRIME;
                        n_state  = S_EMIT;
                    end else begin
                        w_op    = rsakg_pkg::OP_INC_I;
                        n_state = S_PT_CHK;
                    end
                end
            S_MUL: begin
                w_op    = rsakg_pkg::OP_MUL;
                n_state = S_CFG_E;
            end
            S_CFG_E:
                if (i_flags.cfg_zero) begin
                    w_op    = rsakg_pkg::OP_ES_INIT;
                    n_state = S_ES_CHK;
                end else begin
                    w_op    = rsakg_pkg::OP_SEL_E;
                    n_state = S_INV_CHK;
                end
            S_ES_CHK:
                if (i_flags.c_ok) begin
                    w_op    = rsakg_pkg::OP_G_INIT;
                    n_state = S_G_CHK;
                end else begin
                    n_status = rsakg_pkg::ST_NO_INV;
                    n_state  = S_EMIT;
                end
            S_G_CHK:
                if (i_flags.b_zero) begin
                    if (i_flags.a_one) begin
                        w_op    = rsakg_pkg::OP_E_FOUND;
                        n_state = S_INV_CHK;
                    end else begin
                        w_op    = rsakg_pkg::OP_INC_C;
                        n_state = S_ES_CHK;
                    end
                end else begin
                    w_op    = rsakg_pkg::OP_DIV_G;
                    n_state = S_G_DIV;
                end
            S_G_DIV:
                if (i_flags.div_done) begin
                    w_op    = rsakg_pkg::OP_G_STEP;
                    n_state = S_G_CHK;
                end
            S_INV_CHK:
                if (i_flags.phi_lt2) begin
                    n_status = rsakg_pkg::ST_NO_INV;
                    n_state  = S_EMIT;
                end else begin
                    w_op    = rsakg_pkg::OP_INV_INIT;
                    n_state = S_INV_MOD;
                end
            S_INV_MOD:
                if (i_flags.div_done) begin
                    w_op    = rsakg_pkg::OP_R1_SET;
                    n_state = S_EG_CHK;
                end
            S_EG_CHK:
                if (i_flags.r1_zero) begin
                    if (i_flags.r0_one) begin
                        n_state = S_FIN1;
                    end else begin
                        n_status = rsakg_pkg::ST_NO_INV;
                        n_state  = S_EMIT;
                    end
                end else begin
                    w_op    = rsakg_pkg::OP_DIV_EG;
                    n_state = S_EG_DIV;
                end
            S_EG_DIV:
                if (i_flags.div_done) begin
                    w_op    = rsakg_pkg::OP_EG_STEP;
                    n_state = S_EG_CHK;
                end
            S_FIN1: begin
                w_op    = rsakg_pkg::OP_FIN1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                w_op     = rsakg_pkg::OP_FIN2;
                n_status = rsakg_pkg::ST_OK;
                n_state  = S_EMIT;
            end
            S_EMIT:
                if (!i_flags.out_busy) begin
                    w_op    = rsakg_pkg::OP_EMIT;
                    n_state = S_IDLE;
                end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_on_q   <= 1'b0;
            r_status <= rsakg_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_on_q   <= n_on_q;
            r_status <= n_status;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.op     = w_op;
    assign o_cmd.status = r_status;

endmodule

// ===== hdl/small_rsa_key_generator_unit.sv =====
// Top level of the small RSA key generator: APB register, controller, datapath.
`timescale 1ns / 1ps

// One transaction at a time; each trial division (up to 2 x 254) and each Euclid
// step (exponent search and extended Euclid) runs on the single 32-step
// bit-serial divider. A new input is not taken until the result sits in the
// output register. Reset (synchronous, active low): controller idle, output
// empty, public_exponent back to 11.

module small_rsa_key_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsakg_in_if.sink    i_key_in,
    rsakg_out_if.source o_key_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] RegPubExp = 2'd0;

    // Public exponent register; zero selects the coprime search.
    logic [rsakg_pkg::HalfW-1:0] r_pub_exp;

    rsakg_pkg::t_dp_cmd   w_cmd;
    rsakg_pkg::t_dp_flags w_flags;

    // Write on the access phase; other addresses drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_exp <= 16'd11;
        end else if (psel && penable && pwrite && (paddr == RegPubExp)) begin
            r_pub_exp <= pwdata[rsakg_pkg::HalfW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == RegPubExp) ? {16'd0, r_pub_exp} : '0;

    // Controller: hold input ready only while idle, advance on divider status.
    rsakg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key_in.valid),
        .o_in_ready (i_key_in.ready),
        .i_flags    (w_flags),
        .o_cmd      (w_cmd)
    );

    // Datapath: operands, shared divider, and the output register that holds
    // a finished transaction until the sink takes it.
    rsakg_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_flags            (w_flags),
        .i_first_prime      (i_key_in.first_prime),
        .i_second_prime     (i_key_in.second_prime),
        .i_cfg_exp          (r_pub_exp),
        .i_out_ready        (o_key_out.ready),
        .o_out_valid        (o_key_out.valid),
        .o_status           (o_key_out.status),
        .o_modulus          (o_key_out.modulus),
        .o_totient          (o_key_out.totient),
        .o_exponent_used    (o_key_out.exponent_used),
        .o_private_exponent (o_key_out.private_exponent)
    );

endmodule
